// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/fpsum_pkg.sv
// Types and constants of the four-way half-precision sum pipeline.
package fpsum_pkg;

    localparam int ACC_W = 45;          // signed count of 2^-24 units
    localparam int STAGES = 9;          // register stages, output included
    localparam int LEN_W = 6;           // holds bit lengths up to ACC_W
    localparam int SUM_NBITS = 24;      // single-precision significand
    localparam int HALF_NBITS = 11;     // half-precision significand
    localparam logic [15:0] DEFAULT_NAN = 16'hFE00;
    localparam logic [15:0] QUIET_BIT = 16'h0200;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic        is_special;        // running sum is infinite or NaN
        logic [15:0] special;           // result bits when is_special
        acc_t        acc;
        acc_t        p1;
        acc_t        p2;
        acc_t        p3;
    } stage_t;

endpackage

// File: rtl/core/fp16_four_way_sum.sv
// Top level: nine-stage pipeline summing four binary16 parts in single precision.
//
//  channel | ports                          | role
//  s_      | s_valid s_ready s_part_0..3    | four binary16 parts per beat
//  m_      | m_valid m_ready m_merged_sum   | binary16 sum per beat
//
// One beat per cycle sustained while m_ready stays high.
// Stages: decode, then add/round for each of parts 1..3, round to 11 bits, pack.
// Each stage holds only when it is full and the one after it holds, so bubbles
// fill while m_ready is low. Synchronous active-low reset empties the pipe.
module fp16_four_way_sum (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_part_0,
    input  logic [15:0] s_part_1,
    input  logic [15:0] s_part_2,
    input  logic [15:0] s_part_3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_merged_sum
);
    import fpsum_pkg::*;

    logic [STAGES:1] valid_reg;
    logic [STAGES:1] valid_next;
    logic [STAGES+1:1] rdy;
    stage_t          st_reg   [1:STAGES-1];
    stage_t          st_next  [1:STAGES-1];
    logic [15:0]     out_reg;
    logic [15:0]     out_next;
    stage_t          dec;
    acc_t            rnd3, rnd5, rnd7, rnd8;
    logic [15:0]     packed_bits;

    fpsum_decode u_decode (
        .part_0 (s_part_0),
        .part_1 (s_part_1),
        .part_2 (s_part_2),
        .part_3 (s_part_3),
        .dec    (dec)
    );

    fpsum_round #(.NBITS(SUM_NBITS))  u_round3 (.din(st_reg[2].acc), .dout(rnd3));
    fpsum_round #(.NBITS(SUM_NBITS))  u_round5 (.din(st_reg[4].acc), .dout(rnd5));
    fpsum_round #(.NBITS(SUM_NBITS))  u_round7 (.din(st_reg[6].acc), .dout(rnd7));
    fpsum_round #(.NBITS(HALF_NBITS)) u_round8 (.din(st_reg[7].acc), .dout(rnd8));

    fpsum_pack u_pack (.din(st_reg[8].acc), .half_bits(packed_bits));

    // a stage may load when empty or when its content moves on
    always_comb begin
        rdy[STAGES+1] = m_ready;
        for (int k = STAGES; k >= 1; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign s_ready = rdy[1];

    always_comb begin
        valid_next[1] = s_valid;
        for (int k = 2; k <= STAGES; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
        st_next[1] = dec;
        st_next[2] = st_reg[1];
        st_next[2].acc = st_reg[1].acc + st_reg[1].p1;
        st_next[3] = st_reg[2];
        st_next[3].acc = rnd3;
        st_next[4] = st_reg[3];
        st_next[4].acc = st_reg[3].acc + st_reg[3].p2;
        st_next[5] = st_reg[4];
        st_next[5].acc = rnd5;
        st_next[6] = st_reg[5];
        st_next[6].acc = st_reg[5].acc + st_reg[5].p3;
        st_next[7] = st_reg[6];
        st_next[7].acc = rnd7;
        st_next[8] = st_reg[7];
        st_next[8].acc = rnd8;
        out_next = st_reg[8].is_special ? st_reg[8].special : packed_bits;
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= STAGES; k++) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k < STAGES; k++) begin
            if (rdy[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
        if (rdy[STAGES]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = valid_reg[STAGES];
    assign m_merged_sum = out_reg;

endmodule

// File: rtl/core/fpsum_decode.sv
// Widens four half-precision parts to fixed point and folds the special cases.
module fpsum_decode (
    input  logic [15:0]      part_0,
    input  logic [15:0]      part_1,
    input  logic [15:0]      part_2,
    input  logic [15:0]      part_3,
    output fpsum_pkg::stage_t dec
);
    import fpsum_pkg::*;

    logic [15:0] parts [4];
    acc_t        units [4];

    always_comb begin
        logic [4:0]       e;
        logic [9:0]       f;
        logic [ACC_W-1:0] mag;
        logic             is_nan;
        logic             is_inf;
        logic [15:0]      spec;
        parts[0] = part_0;
        parts[1] = part_1;
        parts[2] = part_2;
        parts[3] = part_3;
        is_nan = 1'b0;
        is_inf = 1'b0;
        spec = '0;
        for (int i = 0; i < 4; i++) begin
            e = parts[i][14:10];
            f = parts[i][9:0];
            if (e == 5'd0) begin
                mag = ACC_W'(f);
            end else begin
                mag = ACC_W'({1'b1, f}) << (e - 5'd1);
            end
            units[i] = parts[i][15] ? -acc_t'(mag) : acc_t'(mag);
            // first NaN wins; opposite infinities make the default NaN
            if (!is_nan && e == 5'd31) begin
                if (f != 10'd0) begin
                    is_nan = 1'b1;
                    spec = parts[i] | QUIET_BIT;
                end else if (is_inf && spec != parts[i]) begin
                    is_nan = 1'b1;
                    spec = DEFAULT_NAN;
                end else begin
                    is_inf = 1'b1;
                    spec = parts[i];
                end
            end
        end
        dec.is_special = is_nan | is_inf;
        dec.special = spec;
        dec.acc = units[0];
        dec.p1 = units[1];
        dec.p2 = units[2];
        dec.p3 = units[3];
    end

endmodule

// File: rtl/core/fpsum_round.sv
// Rounds a signed fixed-point value to a number of significant bits, nearest even.
module fpsum_round #(
    parameter int NBITS = 24
) (
    input  logic signed [fpsum_pkg::ACC_W-1:0] din,
    output logic signed [fpsum_pkg::ACC_W-1:0] dout
);
    import fpsum_pkg::*;

    always_comb begin
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] mask;
        logic [ACC_W-1:0] half;
        logic [ACC_W-1:0] rem;
        logic [ACC_W-1:0] res;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] s;
        logic             up;
        mag = din[ACC_W-1] ? ACC_W'(-din) : ACC_W'(din);
        len = '0;
        for (int i = 0; i < ACC_W; i++) begin
            if (mag[i]) len = LEN_W'(i + 1);
        end
        s = (len > LEN_W'(NBITS)) ? len - LEN_W'(NBITS) : '0;
        mask = (ACC_W'(1) << s) - ACC_W'(1);
        half = (s == '0) ? '0 : ACC_W'(1) << (s - LEN_W'(1));
        rem = mag & mask;
        up = (s != '0) && ((rem > half) || ((rem == half) && ((mag >> s) & ACC_W'(1)) != '0));
        res = (mag & ~mask) + (up ? (ACC_W'(1) << s) : '0);
        dout = din[ACC_W-1] ? -acc_t'(res) : acc_t'(res);
    end

endmodule

// File: rtl/core/fpsum_pack.sv
// Packs a value already rounded to eleven significant bits into binary16 bits.
module fpsum_pack (
    input  logic signed [fpsum_pkg::ACC_W-1:0] din,
    output logic [15:0]                        half_bits
);
    import fpsum_pkg::*;

    always_comb begin
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] s;
        logic [LEN_W-1:0] e;
        logic             sign;
        sign = din[ACC_W-1];
        mag = sign ? ACC_W'(-din) : ACC_W'(din);
        len = '0;
        for (int i = 0; i < ACC_W; i++) begin
            if (mag[i]) len = LEN_W'(i + 1);
        end
        s = (len > LEN_W'(HALF_NBITS)) ? len - LEN_W'(HALF_NBITS) : '0;
        r = mag >> s;
        e = s + LEN_W'(1);
        if (mag < ACC_W'(2048)) begin
            half_bits = {sign, 4'd0, mag[10:0]};
        end else if (e >= LEN_W'(31)) begin
            half_bits = {sign, 15'h7C00};
        end else begin
            half_bits = {sign, e[4:0], r[9:0]};
        end
    end

endmodule

// File: rtl/core/fpsum_checker.sv
// Port-level checker for the four-way sum, bound to the top level.
`include "assert_macros.svh"

module fpsum_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_merged_sum
);
    logic [3:0] pending_reg;
    logic [3:0] pending_next;

    always_comb begin
        pending_next = pending_reg + 4'(s_valid && s_ready) - 4'(m_valid && m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `ASSERT_CLK(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_merged_sum), "result dropped or changed while stalled")
    `ASSERT_CLK(a_no_invent, aclk, aresetn, m_valid |-> pending_reg != 4'd0, "result without an accepted beat")
    `ASSERT_CLK(a_depth, aclk, aresetn, pending_reg <= 4'd9, "more beats in flight than stages")
    `ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind fp16_four_way_sum fpsum_checker u_fpsum_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_merged_sum (m_merged_sum)
);

// File: tb/fp16_four_way_sum_tb.sv
// Self-checking testbench for the four-way half-precision sum pipeline.
`timescale 1ns / 100ps

module fp16_four_way_sum_tb;

    typedef enum int {SUM_FIN, SUM_INF, SUM_NAN} sum_kind_e;

    typedef struct {
        logic [15:0] p0;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
    } parts_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_part_0 = '0;
    logic [15:0] s_part_1 = '0;
    logic [15:0] s_part_2 = '0;
    logic [15:0] s_part_3 = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_merged_sum;

    parts_t      pending_parts[$];
    logic [15:0] expected_sums[$];
    int          errors = 0;
    int          sums_seen = 0;
    int          idle_cycles = 0;
    bit          stim_done = 1'b0;
    bit          hold_off = 1'b0;
    bit          s_taken = 1'b0;

    localparam int IDLE_LIMIT = 5000;

    fp16_four_way_sum dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_part_0(s_part_0), .s_part_1(s_part_1),
        .s_part_2(s_part_2), .s_part_3(s_part_3),
        .m_valid(m_valid), .m_ready(m_ready), .m_merged_sum(m_merged_sum)
    );

    always #5 aclk = ~aclk;

    function automatic int bits_used(logic [63:0] m);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++)
            if (m[i]) n = i + 1;
        return n;
    endfunction

    // Round magnitude to nbits significant bits, nearest even.
    function automatic logic [63:0] round_to_bits(logic [63:0] m, int nbits);
        int len;
        int sh;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        len = bits_used(m);
        if (len <= nbits) return m;
        sh = len - nbits;
        keep = m >> sh;
        rem = m & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && keep[0])) keep++;
        return keep << sh;
    endfunction

    function automatic longint half_to_units(logic [15:0] h);
        logic [63:0] m;
        m = (h[14:10] == 0) ? {54'd0, h[9:0]} : ({53'd0, 1'b1, h[9:0]} << (h[14:10] - 1));
        return h[15] ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [15:0] units_to_fp16(longint v);
        logic [15:0] sgn;
        logic [63:0] m;
        int sh;
        logic [63:0] r;
        sgn = (v < 0) ? 16'h8000 : 16'h0000;
        m = (v < 0) ? -v : v;
        m = round_to_bits(m, 11);
        if (m < 2048) return sgn | m[15:0];
        sh = bits_used(m) - 11;
        r = m >> sh;
        if (sh + 1 >= 31) return sgn | 16'h7C00;
        return sgn | 16'(((sh + 1) << 10) + (r - 1024));
    endfunction

    function automatic logic [15:0] predict_sum(parts_t p);
        sum_kind_e   kind;
        longint      acc;
        longint      t;
        logic [63:0] m;
        logic [15:0] special;
        logic [15:0] h;
        logic [15:0] arr[4];
        kind = SUM_FIN;
        acc = 0;
        special = '0;
        arr = '{p.p0, p.p1, p.p2, p.p3};
        for (int i = 0; i < 4; i++) begin
            h = arr[i];
            if (kind == SUM_NAN) continue;
            if (h[14:10] == 5'h1F && h[9:0] != 0) begin
                kind = SUM_NAN;
                special = h | 16'h0200;
            end else if (h[14:10] == 5'h1F) begin
                if (kind == SUM_INF && special != h) begin
                    kind = SUM_NAN;
                    special = 16'hFE00;
                end else begin
                    kind = SUM_INF;
                    special = h;
                end
            end else if (kind == SUM_FIN) begin
                t = acc + half_to_units(h);
                m = (t < 0) ? -t : t;
                m = round_to_bits(m, 24);
                acc = (t < 0) ? -longint'(m) : longint'(m);
            end
        end
        return (kind == SUM_FIN) ? units_to_fp16(acc) : special;
    endfunction

    // Bias toward zeros, subnormals, extremes and specials.
    function automatic logic [15:0] pick_half();
        logic [15:0] h;
        int sel;
        sel = $urandom_range(0, 15);
        h = 16'($urandom);
        case (sel)
            0: h[14:0] = 15'h0000;
            1: h[14:10] = 5'h00;
            2: h[14:0] = 15'h7C00;
            3: h[14:10] = 5'h1F;
            4: h[14:10] = 5'h1E;
            5: h[14:10] = 5'($urandom_range(20, 30));
            default: ;
        endcase
        return h;
    endfunction

    task automatic add_item(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
        parts_t p;
        p = '{a, b, c, d};
        pending_parts.push_back(p);
    endtask

    initial begin
        logic [15:0] base;
        // zeros, all negative zeros, cancellation
        add_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_item(16'h3C00, 16'hBC00, 16'h0000, 16'h8000);
        // largest finite, overflow both signs
        add_item(16'h7BFF, 16'h7BFF, 16'h0000, 16'h0000);
        add_item(16'hFBFF, 16'hFBFF, 16'hFBFF, 16'hFBFF);
        add_item(16'h7BFF, 16'h0000, 16'h0000, 16'h0000);
        // subnormals and rounding ties
        add_item(16'h0001, 16'h0001, 16'h0001, 16'h0001);
        add_item(16'h03FF, 16'h0001, 16'h8001, 16'h0000);
        add_item(16'h3C00, 16'h1000, 16'h0000, 16'h0000);
        add_item(16'h3C01, 16'h1000, 16'h0000, 16'h0000);
        add_item(16'h7000, 16'h0001, 16'h0001, 16'h0001);
        // infinities and opposite infinities
        add_item(16'h7C00, 16'h3C00, 16'h0000, 16'h0000);
        add_item(16'h3C00, 16'hFC00, 16'h7BFF, 16'h0000);
        add_item(16'h7C00, 16'hFC00, 16'h0000, 16'h0000);
        add_item(16'h7C00, 16'h7C00, 16'h7C00, 16'h7C00);
        // NaN first met keeps payload, later ones ignored
        add_item(16'h7C01, 16'h7E00, 16'h0000, 16'h0000);
        add_item(16'h0000, 16'hFD55, 16'h7C01, 16'hFC00);
        add_item(16'h7C00, 16'hFC00, 16'h7D00, 16'h0000);
        add_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        for (int i = 0; i < 1230; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                // near-cancelling parts around a common magnitude
                base = pick_half();
                add_item(base, base ^ 16'h8000 ^ 16'($urandom_range(0, 3)),
                         pick_half() & 16'h83FF, pick_half());
            end else
                add_item(pick_half(), pick_half(), pick_half(), pick_half());
        end
        stim_done = 1'b1;
    end

    // Latch the input handshake at the edge where it counts.
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
    end

    // Driver: bursts of beats with random gaps between them.
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_taken) begin
                pending_parts.pop_front();
                expected_sums.push_back(predict_sum('{s_part_0, s_part_1, s_part_2, s_part_3}));
            end
            if (!s_valid || s_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_parts.size() > 0) begin
                    s_valid <= 1'b1;
                    s_part_0 <= pending_parts[0].p0;
                    s_part_1 <= pending_parts[0].p1;
                    s_part_2 <= pending_parts[0].p2;
                    s_part_3 <= pending_parts[0].p3;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else
                    s_valid <= 1'b0;
            end
        end
    end

    // Receiver: own stall pattern, one long hold-off early in the run.
    int stall_phase = 0;
    int hold_count = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            stall_phase++;
            if (stall_phase == 300) begin
                hold_off = 1'b1;
                hold_count = 0;
            end
            if (hold_off) begin
                hold_count++;
                if (hold_count > 120) hold_off = 1'b0;
                m_ready <= 1'b0;
            end else if ((stall_phase / 64) % 3 == 0)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compare each accepted sum with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                sums_seen++;
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected beat, actual %h", $time, m_merged_sum);
                    errors++;
                end else begin
                    if (m_merged_sum !== expected_sums[0]) begin
                        $display("%0t: merged_sum expected %h actual %h", $time,
                                 expected_sums[0], m_merged_sum);
                        errors++;
                    end
                    expected_sums.pop_front();
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            begin
                wait (stim_done && pending_parts.size() == 0 && !s_valid
                      && expected_sums.size() == 0);
                repeat (20) @(posedge aclk);
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
                $display("%0t: timeout, %0d sums outstanding", $time, expected_sums.size());
                $display("== FAIL ==");
                $finish;
            end
        join_any
        if (expected_sums.size() != 0) begin
            $display("%0t: %0d sums never arrived", $time, expected_sums.size());
            errors++;
        end
        $display("Checked %0d sums over zeros, subnormals, overflow, infinities and NaNs,",
                 sums_seen);
        $display("with bursty input, random output stalls and one long hold-off; %0d errors.",
                 errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
